@@ hw/rtl/pmi_pkg.sv @@
// ----------------------------------------------------------------------------
// pmi_pkg
// Shared types and constants for the point-mass integrator
// ----------------------------------------------------------------------------
package pmi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 31;
  localparam int unsigned NumAx = 3;
  localparam int unsigned FracW = 16;

  localparam logic [1:0] OpStep    = 2'd0;
  localparam logic [1:0] OpLoadPos = 2'd1;
  localparam logic [1:0] OpLoadVel = 2'd2;

  localparam logic [1:0] CfgMass   = 2'd0;
  localparam logic [1:0] CfgStep   = 2'd1;
  localparam logic [1:0] CfgMethod = 2'd2;

  localparam logic [CfgW-1:0] MassRst = 31'd65536;
  localparam logic [CfgW-1:0] StepRst = 31'd6554;

  // per-lane step command from the sequencer
  typedef struct packed {
    logic start;
    logic verlet;
  } lane_ctrl_t;

  typedef struct packed {
    logic done;
  } lane_stat_t;

  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/pmi_div.sv @@
// ----------------------------------------------------------------------------
// pmi_div
// Restoring divider, one quotient bit per cycle, truncates towards zero
// ----------------------------------------------------------------------------
module pmi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [48:0] num_i,
  input  logic        [32:0] den_i,
  output logic               done_o,
  output logic signed [49:0] quo_o
);
  logic        [48:0] mag_q, mag_d;
  logic        [32:0] den_q, den_d;
  logic        [33:0] rem_q, rem_d;
  logic               neg_q, neg_d;
  logic        [5:0]  cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic        [33:0] trial;

  always_comb begin
    mag_d  = mag_q;
    den_d  = den_q;
    rem_d  = rem_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[32:0], mag_q[48]};
    if (start_i) begin
      neg_d  = num_i[48];
      mag_d  = num_i[48] ? 49'(-num_i) : 49'(num_i);
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = 6'd49;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        mag_d = {mag_q[47:0], 1'b1};
      end else begin
        rem_d = trial;
        mag_d = {mag_q[47:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quo_o  = neg_q ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});
endmodule

@@ hw/rtl/pmi_lane.sv @@
// ----------------------------------------------------------------------------
// pmi_lane
// One axis: acceleration divide, then Euler or Verlet update over a few steps
// ----------------------------------------------------------------------------
module pmi_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pmi_pkg::lane_ctrl_t        ctrl_i,
  input  logic signed [31:0]         force_i,
  input  logic        [30:0]         mass_i,
  input  logic        [30:0]         dt_i,
  input  logic        [30:0]         dt2_i,
  input  logic signed [31:0]         pos_i,
  input  logic signed [31:0]         prev_i,
  input  logic signed [31:0]         vel_i,
  output pmi_pkg::lane_stat_t        stat_o,
  output logic signed [31:0]         pos_o,
  output logic signed [31:0]         vel_o
);
  import pmi_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAcc  = 3'd1;
  localparam logic [2:0] StMul1 = 3'd2;
  localparam logic [2:0] StMul2 = 3'd3;
  localparam logic [2:0] StVdiv = 3'd4;
  localparam logic [2:0] StDone = 3'd5;
  localparam logic [2:0] StVst  = 3'd6;

  logic [2:0]         st_q, st_d;
  logic               verlet_q;
  logic signed [31:0] acc_q;
  logic signed [31:0] np_q;
  logic signed [31:0] nv_q;
  logic signed [63:0] prod_q;
  logic               div_start;
  logic signed [48:0] div_num;
  logic        [32:0] div_den;
  logic               div_done;
  logic signed [49:0] div_quo;
  logic signed [30:0] mul_b;
  logic signed [31:0] mul_a;
  logic signed [63:0] mul_p;
  logic signed [32:0] np_diff;

  pmi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign np_diff = $signed({np_q[31], np_q}) - $signed({prev_i[31], prev_i});

  always_comb begin
    div_start = 1'b0;
    div_num   = {force_i[31], force_i, 16'd0};
    div_den   = {2'b0, (mass_i == '0) ? 31'd1 : mass_i};
    if (ctrl_i.start) begin
      div_start = 1'b1;
    end else if (st_q == StVst) begin
      div_start = 1'b1;
      div_num   = {np_diff, 16'd0};
      div_den   = (dt_i == '0) ? 33'd2 : {1'b0, dt_i, 1'b0};
    end
  end

  // single shared multiplier per lane
  always_comb begin
    mul_a = acc_q;
    mul_b = verlet_q ? $signed(dt2_i) : $signed(dt_i);
    if (st_q == StMul2 && !verlet_q) begin
      mul_a = nv_q;
      mul_b = $signed(dt_i);
    end
  end
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (ctrl_i.start) st_d = StAcc;
      StAcc:   if (div_done) st_d = StMul1;
      StMul1:  st_d = StMul2;
      StMul2:  st_d = verlet_q ? StVst : StDone;
      StVst:   st_d = StVdiv;
      StVdiv:  if (div_done) st_d = StDone;
      StDone:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      verlet_q <= ctrl_i.verlet;
    end
    if (st_q == StAcc && div_done) begin
      acc_q <= sat32(66'(div_quo));
    end
    if (st_q == StMul1) begin
      // euler: velocity first; verlet: a*dt2 product
      if (verlet_q) begin
        prod_q <= mul_p;
      end else begin
        nv_q <= sat32(66'($signed({vel_i[31], vel_i})) + 66'(mul_p >>> 16));
      end
    end
    if (st_q == StMul2) begin
      if (verlet_q) begin
        np_q <= sat32(66'($signed({pos_i, 1'b0})) - 66'(prev_i) + 66'(prod_q >>> 16));
      end else begin
        np_q <= sat32(66'(pos_i) + 66'(mul_p >>> 16));
      end
    end
    if (st_q == StVdiv && div_done) begin
      nv_q <= sat32(66'(div_quo));
    end
  end

  assign stat_o.done = (st_q == StDone);
  assign pos_o       = np_q;
  assign vel_o       = nv_q;
endmodule

@@ hw/rtl/point_mass_integrator_core.sv @@
// ----------------------------------------------------------------------------
// point_mass_integrator_core
// Q16.16 point-mass integrator with Euler and Verlet stepping
// ----------------------------------------------------------------------------
// Three axis lanes run side by side and a merge stage commits their results.
// A step runs the bit-serial acceleration divide in each lane, then the
// multiply states, and after the first Verlet-mode step a velocity divide;
// later items wait until the merge stage commits and the output is not stalled.
// Loads and the unused operation answer in the next cycle, and another item
// can follow at once unless the output is stalled. One item is in flight at
// a time; the result sits in an output register.
module point_mass_integrator_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          operation_i,
  input  logic signed [31:0]  vec_x_i,
  input  logic signed [31:0]  vec_y_i,
  input  logic signed [31:0]  vec_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic signed [31:0]  vel_x_o,
  output logic signed [31:0]  vel_y_o,
  output logic signed [31:0]  vel_z_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import pmi_pkg::*;

  logic [30:0]        mass_q, dt_q;
  logic               method_q, stepped_q, busy_q, ov_q;
  logic [30:0]        dt2_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] prev_q [3];
  logic signed [31:0] vel_q [3];
  logic signed [31:0] frc [3];
  logic signed [31:0] lp [3];
  logic signed [31:0] lv [3];
  lane_stat_t         stat [3];
  lane_ctrl_t         ctrl;
  logic               in_acc;
  logic               lanes_done;
  logic [61:0]        dtsq;

  assign in_stall_o  = busy_q || (ov_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign ctrl.start  = in_acc && operation_i == OpStep;
  assign ctrl.verlet = method_q && stepped_q;
  assign frc[0] = vec_x_i;
  assign frc[1] = vec_y_i;
  assign frc[2] = vec_z_i;
  assign dtsq   = dt_q * dt_q;
  assign lanes_done = stat[0].done && stat[1].done && stat[2].done;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pmi_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .force_i(frc[g]),
      .mass_i (mass_q),
      .dt_i   (dt_q),
      .dt2_i  (dt2_q),
      .pos_i  (pos_q[g]),
      .prev_i (prev_q[g]),
      .vel_i  (vel_q[g]),
      .stat_o (stat[g]),
      .pos_o  (lp[g]),
      .vel_o  (lv[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q    <= MassRst;
      dt_q      <= StepRst;
      dt2_q     <= 31'(64'(StepRst) * 64'(StepRst) >> 16);
      method_q  <= 1'b0;
      stepped_q <= 1'b0;
      busy_q    <= 1'b0;
      ov_q      <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  <= '0;
        prev_q[i] <= '0;
        vel_q[i]  <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgMass:   mass_q   <= cfg_data_i[30:0];
          CfgStep:   dt_q     <= cfg_data_i[30:0];
          CfgMethod: method_q <= cfg_data_i[0];
          default:   ;
        endcase
      end
      // dt squared is registered from dt and follows it in the next cycle
      dt2_q <= (dtsq[61:16] > 46'h7fffffff) ? 31'h7fffffff : dtsq[46:16];
      if (ov_q && !out_stall_i) begin
        ov_q <= 1'b0;
      end
      if (in_acc) begin
        unique case (operation_i)
          OpStep: busy_q <= 1'b1;
          OpLoadPos: begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i]  <= frc[i];
              prev_q[i] <= frc[i];
            end
            ov_q <= 1'b1;
          end
          OpLoadVel: begin
            for (int i = 0; i < 3; i++) vel_q[i] <= frc[i];
            ov_q <= 1'b1;
          end
          default: ov_q <= 1'b1;
        endcase
      end
      // merge stage: all lanes finish together
      if (busy_q && lanes_done) begin
        for (int i = 0; i < 3; i++) begin
          prev_q[i] <= pos_q[i];
          pos_q[i]  <= lp[i];
          vel_q[i]  <= lv[i];
        end
        stepped_q <= 1'b1;
        busy_q    <= 1'b0;
        ov_q      <= 1'b1;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign pos_x_o = pos_q[0];
  assign pos_y_o = pos_q[1];
  assign pos_z_o = pos_q[2];
  assign vel_x_o = vel_q[0];
  assign vel_y_o = vel_q[1];
  assign vel_z_o = vel_q[2];
endmodule

@@ tb/tb_point_mass_integrator_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_mass_integrator_core
// Checks the point-mass integrator against its own Q16.16 particle model
// ----------------------------------------------------------------------------
// A directed table covers the field extremes, every operation and the first
// step in Verlet mode. Random items then run through several register
// settings (zero mass, zero time step) with random idling on both channels.
// Each result is compared with the oldest expected position and velocity.
module tb_point_mass_integrator_core;
  import pmi_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseItems = 170;
  localparam longint      S32Max     = 64'sd2147483647;
  localparam longint      S32Min     = -64'sd2147483648;
  localparam logic [1:0]  OpNone     = 2'd3;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } motion_t;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 known;
    motion_t            res;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         operation_i;
  logic signed [31:0] vec_x_i;
  logic signed [31:0] vec_y_i;
  logic signed [31:0] vec_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] pos_x_o;
  logic signed [31:0] pos_y_o;
  logic signed [31:0] pos_z_o;
  logic signed [31:0] vel_x_o;
  logic signed [31:0] vel_y_o;
  logic signed [31:0] vel_z_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i;
  logic [31:0]        cfg_data_i;

  // particle model state
  logic [30:0]        mass_q;
  logic [30:0]        dt_q;
  logic               verlet_q;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] prev_q [3];
  logic signed [31:0] vel_q [3];
  logic               stepped_q;

  motion_t     expected_motion_q [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned hold_left;

  point_mass_integrator_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > S32Max) return S32Max;
    if (v < S32Min) return S32Min;
    return v;
  endfunction

  function automatic motion_t advance_particle(logic [1:0] op, logic signed [31:0] x,
                                               logic signed [31:0] y, logic signed [31:0] z);
    logic signed [31:0] vin [3];
    logic signed [31:0] np [3];
    logic signed [31:0] nv [3];
    longint m, dt, dt2, two_dt, acc, p;
    motion_t r;
    vin[0] = x;
    vin[1] = y;
    vin[2] = z;
    if (op == OpStep) begin
      m      = (mass_q == 0) ? 64'sd1 : longint'(mass_q);
      dt     = longint'(dt_q);
      dt2    = (dt * dt) >>> 16;
      if (dt2 > S32Max) dt2 = S32Max;
      two_dt = (dt == 0) ? 64'sd2 : 2 * dt;
      for (int i = 0; i < 3; i++) begin
        acc = clamp32((longint'(vin[i]) * 65536) / m);
        if (verlet_q && stepped_q) begin
          p     = 2 * longint'(pos_q[i]) - longint'(prev_q[i]) + ((acc * dt2) >>> 16);
          np[i] = clamp32(p);
          nv[i] = clamp32(((longint'(np[i]) - longint'(prev_q[i])) * 65536) / two_dt);
        end else begin
          nv[i] = clamp32(longint'(vel_q[i]) + ((acc * dt) >>> 16));
          np[i] = clamp32(longint'(pos_q[i]) + ((longint'(nv[i]) * dt) >>> 16));
        end
      end
      for (int i = 0; i < 3; i++) begin
        prev_q[i] = pos_q[i];
        pos_q[i]  = np[i];
        vel_q[i]  = nv[i];
      end
      stepped_q = 1'b1;
    end else if (op == OpLoadPos) begin
      for (int i = 0; i < 3; i++) begin
        pos_q[i]  = vin[i];
        prev_q[i] = vin[i];
      end
    end else if (op == OpLoadVel) begin
      for (int i = 0; i < 3; i++) vel_q[i] = vin[i];
    end
    r = '{pos_q[0], pos_q[1], pos_q[2], vel_q[0], vel_q[1], vel_q[2]};
    return r;
  endfunction

  task automatic report(string what, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) begin
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    motion_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_motion_q.size() == 0) begin
        $display("mismatch: result with nothing expected");
        err_cnt++;
      end else begin
        e = expected_motion_q.pop_front();
        report("pos_x", pos_x_o, e.px);
        report("pos_y", pos_y_o, e.py);
        report("pos_z", pos_z_o, e.pz);
        report("vel_x", vel_x_o, e.vx);
        report("vel_y", vel_y_o, e.vy);
        report("vel_z", vel_z_o, e.vz);
      end
    end
  end

  // receiver stall, with a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, bit known, motion_t res);
    motion_t pred;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    vec_x_i     <= x;
    vec_y_i     <= y;
    vec_z_i     <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = advance_particle(op, x, y, z);
    expected_motion_q.push_back(known ? res : pred);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_motion_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgMass:   mass_q   = data[30:0];
      CfgStep:   dt_q     = data[30:0];
      CfgMethod: verlet_q = data[0];
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
      1: return $urandom_range(1) ? -32'sd1 : 32'sd0;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
    endcase
  endfunction

  function automatic logic [1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 72) return OpStep;
    if (r < 83) return OpLoadPos;
    if (r < 94) return OpLoadVel;
    return OpNone;
  endfunction

  initial begin
    stim_row_t rows [12];
    logic [31:0] phase_cfg [NumPhases][3];
    int unsigned sent;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    operation_i = OpStep;
    vec_x_i     = '0;
    vec_y_i     = '0;
    vec_z_i     = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgMass;
    cfg_data_i  = '0;
    err_cnt     = 0;
    cycle_cnt   = 0;
    hold_left   = 0;
    tx_idle_pct = 24;
    rx_idle_pct = 66;
    mass_q      = MassRst;
    dt_q        = StepRst;
    verlet_q    = 1'b0;
    stepped_q   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pos_q[i]  = '0;
      prev_q[i] = '0;
      vel_q[i]  = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // verlet selected before the first step, which must still be euler
    write_reg(CfgMethod, 32'd1);

    rows[0]  = '{OpNone, 0, 0, 0, 1'b1, '{0, 0, 0, 0, 0, 0}};
    rows[1]  = '{OpLoadPos, 32'sh7fffffff, 32'sh80000000, 0, 1'b1,
                 '{32'sh7fffffff, 32'sh80000000, 0, 0, 0, 0}};
    rows[2]  = '{OpLoadVel, 32'sh80000000, 32'sh7fffffff, 1, 1'b1,
                 '{32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 1}};
    rows[3]  = '{OpStep, 0, 0, 0, 1'b0, '0};
    rows[4]  = '{OpStep, 32'sh7fffffff, 32'sh80000000, -1, 1'b0, '0};
    rows[5]  = '{OpStep, 32'sh80000000, 32'sh7fffffff, 0, 1'b0, '0};
    rows[6]  = '{OpLoadPos, 32'sh00010000, -32'sh00010000, 32'sh7fff0000, 1'b0, '0};
    rows[7]  = '{OpStep, 32'sh12345678, -1, 1, 1'b0, '0};
    rows[8]  = '{OpNone, 32'shffffffff, 32'sh55555555, 32'sh2aaaaaaa, 1'b0, '0};
    rows[9]  = '{OpLoadVel, 0, 0, 0, 1'b0, '0};
    rows[10] = '{OpStep, 32'sh00010000, 32'sh00010000, -32'sh00010000, 1'b0, '0};
    rows[11] = '{OpStep, 0, 0, 0, 1'b0, '0};
    foreach (rows[i]) send_item(rows[i].op, rows[i].x, rows[i].y, rows[i].z,
                                rows[i].known, rows[i].res);
    drain();

    // mass, time step, method per phase; zero mass and zero step included
    phase_cfg[0] = '{32'h00010000, 32'd6554, 32'd0};
    phase_cfg[1] = '{32'd0, 32'd6554, 32'd1};
    phase_cfg[2] = '{32'd1, 32'd1, 32'd1};
    phase_cfg[3] = '{32'hffffffff, 32'h7fffffff, 32'd0};
    phase_cfg[4] = '{32'h00010000, 32'd0, 32'd1};
    phase_cfg[5] = '{32'h00010000, 32'd0, 32'd0};
    phase_cfg[6] = '{32'h00020000, 32'hffffffff, 32'd1};
    phase_cfg[7] = '{32'h00030000, 32'd655, 32'd1};
    phase_cfg[8] = '{32'h00008000, 32'd13107, 32'd0};

    sent = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(CfgMass, phase_cfg[ph][0]);
      write_reg(CfgStep, phase_cfg[ph][1]);
      write_reg(CfgMethod, phase_cfg[ph][2]);
      if (ph == 2) hold_left = 600;
      for (int n = 0; n < PhaseItems; n++) begin
        case (sent * 3 / (NumPhases * PhaseItems))
          0: begin tx_idle_pct = 24; rx_idle_pct = 66; end
          1: begin tx_idle_pct = 66; rx_idle_pct = 24; end
          default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
        send_item(pick_op(), pick_value(), pick_value(), pick_value(), 1'b0, '0);
        sent++;
        // sender pauses once until the block has emptied
        if (ph == 5 && n == PhaseItems / 2) drain();
      end
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
